/* hw/rtl/pmle_pkg.sv */
// Match-list engine package: status and function codes, flag bits, and the
// structs shared by the slot cells and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmle_pkg;

    localparam int ENTRY_COUNT_DEF  = 64;
    localparam int PORTAL_COUNT_DEF = 16;
    // widest slot index over the allowed entry counts (up to 1024)
    localparam int IDXW = 10;

    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_UNLINK = 2'd1;
    localparam logic [1:0] FN_PUT    = 2'd2;
    localparam logic [1:0] FN_GET    = 2'd3;

    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_UNLINKED = 3'd1;
    localparam logic [2:0] ST_SLOT_ERR = 3'd2;
    localparam logic [2:0] ST_DROPPED  = 3'd3;
    localparam logic [2:0] ST_NO_MATCH = 3'd4;
    localparam logic [2:0] ST_MATCHED  = 3'd5;

    localparam int FL_NO_TRUNC = 0;
    localparam int FL_MANAGE   = 1;
    localparam int FL_ONCE     = 2;
    localparam int FL_NO_UEVT  = 3;

    localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

    // one captured input item
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  portal;
        logic        lsel;
        logic [5:0]  handle;
        logic [63:0] mb;
        logic [63:0] ign;
        logic [31:0] nid;
        logic [31:0] pid;
        logic [3:0]  flags;
        logic [31:0] len;
        logic [31:0] off;
    } item_t;

    // best candidate of one list so far
    typedef struct packed {
        logic            found;
        logic [IDXW-1:0] idx;
        logic [31:0]     gap;
        logic [3:0]      flags;
        logic [31:0]     length;
        logic [31:0]     free_floor;
        logic [31:0]     loc_off;
    } best_t;

    // search wave handed from cell to cell
    typedef struct packed {
        best_t prio;
        best_t ovf;
    } carry_t;

    // slot write command broadcast to all cells
    typedef struct packed {
        logic            append;
        logic            clear;
        logic            set_off;
        logic [IDXW-1:0] idx;
        logic [31:0]     new_off;
    } wr_t;

endpackage
`default_nettype wire

/* hw/rtl/pmle_cell.sv */
// One slot of the match table: holds the entry and folds its match result
// into the search wave passed on to the next cell. Uses pmle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmle_cell #(
    parameter int IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pmle_pkg::item_t item,
    input  wire logic [32:0]     hend,
    input  wire logic [31:0]     seq,
    input  wire pmle_pkg::wr_t   wr,
    input  wire pmle_pkg::carry_t cin,
    output pmle_pkg::carry_t     cout,
    output logic                 valid
);

    logic        valid_reg;
    logic [63:0] mb_reg;
    logic [63:0] ign_reg;
    logic [31:0] node_reg;
    logic [31:0] proc_reg;
    logic [3:0]  flags_reg;
    logic [31:0] len_reg;
    logic [31:0] free_floor_reg;
    logic [31:0] loc_off_reg;
    logic [3:0]  portal_reg;
    logic        list_reg;
    logic [31:0] age_reg;
    pmle_pkg::carry_t carry_reg;
    pmle_pkg::carry_t carry_next;
    pmle_pkg::best_t  cand;
    logic        me;
    logic        hit;

    assign me = (wr.idx == pmle_pkg::IDXW'(IDX));

    // entry storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (me && wr.append)
        begin
            valid_reg <= 1'b1;
        end
        else if (me && wr.clear)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (me && wr.append)
        begin
            mb_reg         <= item.mb;
            ign_reg        <= item.ign;
            node_reg       <= item.nid;
            proc_reg       <= item.pid;
            flags_reg      <= item.flags;
            len_reg        <= item.len;
            free_floor_reg <= item.off;
            loc_off_reg    <= 32'd0;
            portal_reg     <= item.portal;
            list_reg       <= item.lsel;
            age_reg        <= seq;
        end
        else if (me && wr.set_off)
        begin
            loc_off_reg <= wr.new_off;
        end
    end

    // match test against the header
    always_comb
    begin
        hit = valid_reg && (portal_reg == item.portal)
            && (((item.mb ^ mb_reg) & ~ign_reg) == 64'd0)
            && !(flags_reg[pmle_pkg::FL_NO_TRUNC] && (hend > {1'b0, len_reg}))
            && ((node_reg == pmle_pkg::ALL32) || (node_reg == item.nid))
            && ((proc_reg == pmle_pkg::ALL32) || (proc_reg == item.pid));
        cand.found      = 1'b1;
        cand.idx        = pmle_pkg::IDXW'(IDX);
        cand.gap        = seq - age_reg;
        cand.flags      = flags_reg;
        cand.length     = len_reg;
        cand.free_floor = free_floor_reg;
        cand.loc_off    = loc_off_reg;
        carry_next = cin;
        // older entry (greater distance) wins
        if (hit && !list_reg && (!cin.prio.found || cand.gap > cin.prio.gap))
        begin
            carry_next.prio = cand;
        end
        if (hit && list_reg && (!cin.ovf.found || cand.gap > cin.ovf.gap))
        begin
            carry_next.ovf = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign cout  = carry_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

/* hw/rtl/portals_match_list_engine.sv */
// Match-list engine top level: command decode, search sequencing over the
// chain of pmle_cell slots, and put/get finishing. Uses pmle_pkg, pmle_cell.
`timescale 1ns / 1ps
`default_nettype none
// Append and unlink items, and headers dropped on a disabled portal, finish
// in S_DEC, which raises the registered done strobe. A put or get header
// enters S_SRCH, where the search wave walks the chain of slot cells one
// cell per cycle, then S_FIN1 and S_FIN2 pick the entry and finish the put/get
// update. busy is high from the accepting edge until done; done is high for a
// single cycle and each result must be taken then, though the result outputs
// hold until the next command is decoded. The configuration channel is always ready.
module portals_match_list_engine #(
    parameter int ENTRY_COUNT  = pmle_pkg::ENTRY_COUNT_DEF,
    parameter int PORTAL_COUNT = pmle_pkg::PORTAL_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  portal,
    input  wire logic        list_select,
    input  wire logic [5:0]  entry_handle,
    input  wire logic [63:0] match_key,
    input  wire logic [63:0] ignore_mask,
    input  wire logic [31:0] node_id,
    input  wire logic [31:0] process_id,
    input  wire logic [3:0]  entry_flags,
    input  wire logic [31:0] byte_length,
    input  wire logic [31:0] offset_or_floor,
    output logic [2:0]       status,
    output logic [5:0]       hit_handle,
    output logic             hit_list,
    output logic [31:0]      data_offset,
    output logic [31:0]      moved_length,
    output logic             auto_unlinked,
    output logic             unlink_event
);

    localparam int IW = $clog2(ENTRY_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_FIN1 = 3'd3;
    localparam logic [2:0] S_FIN2 = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [15:0] mask_reg;
    logic [31:0] seq_reg, seq_next;
    pmle_pkg::item_t item_reg;
    logic [32:0] hend_reg;

    // finish stage registers
    pmle_pkg::best_t fin_reg;
    logic        fin_list_reg;
    logic [31:0] fin_doff_reg;
    logic [31:0] fin_mlen_reg;
    logic [31:0] fin_off_reg;

    // result registers
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic [5:0]  hit_reg, hit_next;
    logic        hlist_reg, hlist_next;
    logic [31:0] doff_reg, doff_next;
    logic [31:0] mlen_reg, mlen_next;
    logic        aul_reg, aul_next;
    logic        uev_reg, uev_next;

    pmle_pkg::wr_t    wr;
    pmle_pkg::carry_t carry [0:ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] valid_vec;

    logic [31:0] h32;
    logic [IW-1:0] hidx;
    logic        in_range;
    logic        portal_ok;
    pmle_pkg::best_t sel;
    logic        sel_list;
    logic        is_put;
    logic        manage;
    logic [31:0] f1_doff;
    logic [31:0] f1_off;
    logic [31:0] f1_room;
    logic [31:0] f1_mlen;
    logic [32:0] f1_sum;
    logic [31:0] f2_free;
    logic        f2_aul;

    assign h32       = 32'(item_reg.handle);
    assign hidx      = h32[IW-1:0];
    assign in_range  = h32 < 32'(ENTRY_COUNT);
    assign portal_ok = 32'(item_reg.portal) < 32'(PORTAL_COUNT);
    assign is_put    = (item_reg.func == pmle_pkg::FN_PUT);

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= cfg_data;
        end
    end

    // slot chain
    assign carry[0] = '0;
    for (genvar g = 0; g < ENTRY_COUNT; g++)
    begin : g_cell
        pmle_cell #(.IDX(g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .item  (item_reg),
            .hend  (hend_reg),
            .seq   (seq_reg),
            .wr    (wr),
            .cin   (carry[g]),
            .cout  (carry[g+1]),
            .valid (valid_vec[g])
        );
    end

    // first finish step: pick the entry, offset and truncation
    always_comb
    begin
        sel_list = !carry[ENTRY_COUNT].prio.found;
        sel      = sel_list ? carry[ENTRY_COUNT].ovf : carry[ENTRY_COUNT].prio;
        manage   = is_put && sel.flags[pmle_pkg::FL_MANAGE];
        f1_doff  = manage ? sel.loc_off : item_reg.off;
        f1_sum   = {1'b0, sel.loc_off} + {1'b0, item_reg.len};
        f1_off   = manage ? (f1_sum[32] ? pmle_pkg::ALL32 : f1_sum[31:0]) : sel.loc_off;
        f1_room  = (sel.length > f1_doff) ? (sel.length - f1_doff) : 32'd0;
        f1_mlen  = item_reg.len;
        if (is_put && !sel.flags[pmle_pkg::FL_NO_TRUNC] && (item_reg.len > f1_room))
        begin
            f1_mlen = f1_room;
        end
    end

    // second finish step: auto unlink
    always_comb
    begin
        f2_free = (fin_reg.length > fin_off_reg) ? (fin_reg.length - fin_off_reg) : 32'd0;
        f2_aul  = fin_reg.flags[pmle_pkg::FL_ONCE]
                || (is_put && (f2_free < fin_reg.free_floor));
    end

    // control and result next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        seq_next    = seq_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        hit_next    = hit_reg;
        hlist_next  = hlist_reg;
        doff_next   = doff_reg;
        mlen_next   = mlen_reg;
        aul_next    = aul_reg;
        uev_next    = uev_reg;
        wr          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                hit_next   = 6'd0;
                hlist_next = 1'b0;
                doff_next  = 32'd0;
                mlen_next  = 32'd0;
                aul_next   = 1'b0;
                uev_next   = 1'b0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                wr.idx     = pmle_pkg::IDXW'(item_reg.handle);
                if (item_reg.func == pmle_pkg::FN_APPEND)
                begin
                    if (in_range && portal_ok && !valid_vec[hidx])
                    begin
                        wr.append   = 1'b1;
                        seq_next    = seq_reg + 32'd1;
                        status_next = pmle_pkg::ST_APPENDED;
                    end
                    else
                    begin
                        status_next = pmle_pkg::ST_SLOT_ERR;
                    end
                end
                else if (item_reg.func == pmle_pkg::FN_UNLINK)
                begin
                    if (in_range && valid_vec[hidx])
                    begin
                        wr.clear    = 1'b1;
                        status_next = pmle_pkg::ST_UNLINKED;
                    end
                    else
                    begin
                        status_next = pmle_pkg::ST_SLOT_ERR;
                    end
                end
                else if (!portal_ok || !mask_reg[item_reg.portal])
                begin
                    status_next = pmle_pkg::ST_DROPPED;
                end
                else
                begin
                    done_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(ENTRY_COUNT - 1))
                begin
                    state_next = S_FIN1;
                end
            end
            S_FIN1:
            begin
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!fin_reg.found)
                begin
                    status_next = pmle_pkg::ST_NO_MATCH;
                end
                else
                begin
                    status_next = pmle_pkg::ST_MATCHED;
                    hit_next    = fin_reg.idx[5:0];
                    hlist_next  = fin_list_reg;
                    doff_next   = fin_doff_reg;
                    mlen_next   = fin_mlen_reg;
                    aul_next    = f2_aul;
                    uev_next    = is_put && f2_aul && !fin_reg.flags[pmle_pkg::FL_NO_UEVT];
                    wr.idx      = fin_reg.idx;
                    wr.clear    = f2_aul;
                    wr.set_off  = is_put && fin_reg.flags[pmle_pkg::FL_MANAGE];
                    wr.new_off  = fin_off_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            seq_reg   <= 32'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seq_reg   <= seq_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hit_reg    <= hit_next;
        hlist_reg  <= hlist_next;
        doff_reg   <= doff_next;
        mlen_reg   <= mlen_next;
        aul_reg    <= aul_next;
        uev_reg    <= uev_next;
        if (state_reg == S_IDLE && start)
        begin
            item_reg.func   <= func;
            item_reg.portal <= portal;
            item_reg.lsel   <= list_select;
            item_reg.handle <= entry_handle;
            item_reg.mb     <= match_key;
            item_reg.ign    <= ignore_mask;
            item_reg.nid    <= node_id;
            item_reg.pid    <= process_id;
            item_reg.flags  <= entry_flags;
            item_reg.len    <= byte_length;
            item_reg.off    <= offset_or_floor;
            hend_reg        <= {1'b0, offset_or_floor} + {1'b0, byte_length};
        end
        if (state_reg == S_FIN1)
        begin
            fin_reg      <= sel;
            fin_list_reg <= sel_list;
            fin_doff_reg <= f1_doff;
            fin_mlen_reg <= f1_mlen;
            fin_off_reg  <= f1_off;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign hit_handle    = hit_reg;
    assign hit_list      = hlist_reg;
    assign data_offset   = doff_reg;
    assign moved_length  = mlen_reg;
    assign auto_unlinked = aul_reg;
    assign unlink_event  = uev_reg;

    // checks
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_DEC || $past(state_reg) == S_FIN2))
        else $error("done without a finishing state");
    a_uev_aul: assert property (@(posedge clk) disable iff (!rst_n)
        (done && unlink_event) |-> auto_unlinked)
        else $error("unlink event without auto unlink");
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != pmle_pkg::ST_MATCHED) |-> (hit_handle == 6'd0 && !hit_list
            && data_offset == 32'd0 && moved_length == 32'd0 && !auto_unlinked))
        else $error("result fields set without a match");
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |=> busy)
        else $error("search left without finishing");

endmodule
`default_nettype wire
